// ----- hw/rtl/bms_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bms_pkg: shared types and codes for the bracket match stack
// Holds the transfer payload structs, status and kind codes, and the
// per-cycle control handed along the row of stack cells.
// ----------------------------------------------------------------------------
package bms_pkg;

	localparam int KindW  = 2;
	localparam int LineW  = 20;
	localparam int ColW   = 16;
	localparam int DepthW = 9;

	typedef enum logic {
		MODE_OPEN  = 1'b0,
		MODE_CLOSE = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_MISMATCH = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// Kind code for no known bracket; an unknown open on top matches any close
	localparam logic [KindW-1:0] KIND_UNKNOWN = 2'd3;

	typedef struct packed {
		logic              mode;
		logic [KindW-1:0]  kind;
		logic [LineW-1:0]  src_line;
		logic [ColW-1:0]   src_col;
	} item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [KindW-1:0]  expected_kind;
		logic [LineW-1:0]  expected_line;
		logic [ColW-1:0]   expected_col;
		logic [DepthW-1:0] depth;
	} result_t;

	// Shift control for every cell in the row
	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bracket_match_stack.sv -----
`default_nettype none
// A result strobes on done in the cycle after start is taken.
// Throughput: one item per cycle; busy stays low, since the top of stack
// sits in cell 0 of the shift row and is ready every cycle.
// Reset: arst_n clears the depth and the result strobe; entries are not
// cleared, only entries below the depth are ever read. Results cannot stall.
// ----------------------------------------------------------------------------
// bracket_match_stack: balanced bracket checker
// Keeps open brackets in a row of shift cells with the top in cell 0;
// checks each close against the top and reports status and depth.
// ----------------------------------------------------------------------------
module bracket_match_stack
	import bms_pkg::*;
#(
	parameter int STACK_DEPTH = 256,
	parameter int LINE_BITS   = 20,
	parameter int COL_BITS    = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire item_t   item,
	output logic         done,
	output result_t      result
);

	localparam int EntryW = KindW + LINE_BITS + COL_BITS;
	localparam int CntW   = $clog2(STACK_DEPTH + 1);

	logic [EntryW-1:0] cell_data [STACK_DEPTH];
	logic [EntryW-1:0] push_entry;
	logic [KindW-1:0]  top_kind;
	logic [LINE_BITS-1:0] tos_line;
	logic [COL_BITS-1:0]  top_col;
	logic [CntW-1:0]   depth_q;
	logic [CntW-1:0]   depth_next;
	logic              accept;
	logic              stack_empty;
	logic              is_full;
	logic              mismatch;
	shift_ctl_t        ctl;
	result_t           res_next;
	result_t           result_q;
	logic              done_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Pack the incoming entry and unpack the top of stack
	assign push_entry = {item.kind, LINE_BITS'(item.src_line), COL_BITS'(item.src_col)};
	assign {top_kind, tos_line, top_col} = cell_data[0];

	assign stack_empty = (depth_q == '0);
	assign is_full     = (depth_q == CntW'(STACK_DEPTH));
	assign mismatch    = (top_kind != KIND_UNKNOWN) && (top_kind != item.kind);

	// Decide the step and the result
	always_comb begin
		ctl        = '0;
		depth_next = depth_q;
		res_next   = '0;
		if (item.mode == MODE_OPEN) begin
			if (is_full) begin
				res_next.status = ST_FULL;
			end else begin
				ctl.push   = accept;
				depth_next = depth_q + CntW'(1);
			end
		end else if (stack_empty) begin
			res_next.status = ST_EMPTY;
		end else if (mismatch) begin
			res_next.status        = ST_MISMATCH;
			res_next.expected_kind = top_kind;
			res_next.expected_line = LineW'(tos_line);
			res_next.expected_col  = ColW'(top_col);
		end else begin
			ctl.pop    = accept;
			depth_next = depth_q - CntW'(1);
		end
		res_next.depth = DepthW'(depth_next);
	end

	// Row of cells; the bottom cell holds on a pop
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [EntryW-1:0] upper;
		logic [EntryW-1:0] lower;
		if (i == 0) begin : g_top
			assign upper = push_entry;
		end else begin : g_mid
			assign upper = cell_data[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign lower = cell_data[i];
		end else begin : g_inner
			assign lower = cell_data[i+1];
		end
		bms_cell #(
			.EntryW(EntryW)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.upper(upper),
			.lower(lower),
			.entry(cell_data[i])
		);
	end

	// Advance depth and strobe the result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				depth_q <= depth_next;
			end
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= res_next;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ----- hw/rtl/bms_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bms_cell: one stack entry
// Takes the entry above it on a push, the entry below it on a pop, and
// holds otherwise.
// ----------------------------------------------------------------------------
module bms_cell
	import bms_pkg::*;
#(
	parameter int EntryW = 38
) (
	input  wire logic              clk,
	input  wire shift_ctl_t        ctl,
	input  wire logic [EntryW-1:0] upper,
	input  wire logic [EntryW-1:0] lower,
	output logic      [EntryW-1:0] entry
);

	logic [EntryW-1:0] entry_q;

	// Shift toward the bottom on push, toward the top on pop
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= upper;
		end else if (ctl.pop) begin
			entry_q <= lower;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the bracket match stack
// Drives open and close bracket events through the start/busy handshake,
// tracks the expected stack in a scoreboard and checks every strobed report
// field by field. Runs a directed opening, then random nesting with fills
// to full and overflow, under changing sender idle rates.
// ----------------------------------------------------------------------------
module tb;
	import bms_pkg::*;

	localparam int STACK_SIZE   = 256;
	localparam int TOTAL_ITEMS  = 1250;
	localparam int STALL_LIMIT  = 5000;
	localparam int REPORT_LIMIT = 10;

	localparam logic [KindW-1:0] KIND_PAREN  = 2'd0;
	localparam logic [KindW-1:0] KIND_SQUARE = 2'd1;
	localparam logic [KindW-1:0] KIND_BRACE  = 2'd2;

	// Track open brackets and the report each event should produce
	class bracket_scoreboard;
		logic [KindW-1:0] open_kind [STACK_SIZE];
		logic [LineW-1:0] open_line [STACK_SIZE];
		logic [ColW-1:0]  open_col  [STACK_SIZE];
		int               open_count;
		result_t          pending_reports [$];
		int               bad_reports;

		function new();
			open_count  = 0;
			bad_reports = 0;
		endfunction

		function logic [KindW-1:0] top_kind();
			return open_kind[open_count-1];
		endfunction

		function void note_bracket(item_t it);
			result_t want;
			int      top;
			want        = '0;
			want.status = ST_OK;
			top         = open_count - 1;
			if (it.mode == MODE_OPEN) begin
				if (open_count >= STACK_SIZE) begin
					want.status = ST_FULL;
				end else begin
					open_kind[open_count] = it.kind;
					open_line[open_count] = it.src_line;
					open_col[open_count]  = it.src_col;
					open_count++;
				end
			end else if (open_count == 0) begin
				want.status = ST_EMPTY;
			end else if (open_kind[top] != KIND_UNKNOWN && open_kind[top] != it.kind) begin
				want.status        = ST_MISMATCH;
				want.expected_kind = open_kind[top];
				want.expected_line = open_line[top];
				want.expected_col  = open_col[top];
			end else begin
				open_count--;
			end
			want.depth = DepthW'(open_count);
			pending_reports.push_back(want);
		endfunction

		function void check_report(result_t got);
			result_t want;
			bit      ok;
			if (pending_reports.size() == 0) begin
				bad_reports++;
				if (bad_reports <= REPORT_LIMIT)
					$display("%0t: report with none pending: status %0d depth %0d",
						$realtime, got.status, got.depth);
				return;
			end
			want = pending_reports.pop_front();
			ok = (got.status === want.status) && (got.expected_kind === want.expected_kind)
				&& (got.expected_line === want.expected_line)
				&& (got.expected_col === want.expected_col) && (got.depth === want.depth);
			if (!ok) begin
				bad_reports++;
				if (bad_reports <= REPORT_LIMIT)
					$display({"%0t: wrong report: status %0d/%0d kind %0d/%0d line %h/%h ",
						"col %h/%h depth %0d/%0d (expected/actual)"}, $realtime,
						want.status, got.status, want.expected_kind, got.expected_kind,
						want.expected_line, got.expected_line, want.expected_col,
						got.expected_col, want.depth, got.depth);
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;

	bracket_scoreboard sb;
	int                gap_pct;
	int                sent_count;
	int                quiet_cycles;

	bracket_match_stack uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	// Free-running clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic item_t make_bracket(logic mode, logic [KindW-1:0] kind,
		logic [LineW-1:0] line_no, logic [ColW-1:0] col_no);
		item_t it;
		it.mode     = mode;
		it.kind     = kind;
		it.src_line = line_no;
		it.src_col  = col_no;
		return it;
	endfunction

	// Open of a random kind, now and then the unknown kind
	function automatic item_t random_open();
		logic [KindW-1:0] k;
		k = ($urandom_range(19) == 0) ? KIND_UNKNOWN : KindW'($urandom_range(2));
		return make_bracket(MODE_OPEN, k, LineW'($urandom), ColW'($urandom));
	endfunction

	// Close that pops the current top
	function automatic item_t matching_close();
		logic [KindW-1:0] k;
		k = (sb.top_kind() == KIND_UNKNOWN) ? KindW'($urandom_range(3)) : sb.top_kind();
		return make_bracket(MODE_CLOSE, k, LineW'($urandom), ColW'($urandom));
	endfunction

	function automatic item_t random_bracket();
		return make_bracket(1'($urandom_range(1)), KindW'($urandom_range(3)),
			LineW'($urandom), ColW'($urandom));
	endfunction

	// Offer one event, idling at random first; note it once the transfer happens
	task automatic send_bracket(input item_t it);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_bracket(it);
		sent_count++;
	endtask

	// Hold the sender until every pending report has arrived
	task automatic drain_reports();
		start <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending_reports.size() != 0);
		@(posedge clk);
	endtask

	// Check each strobed report
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_report(result);
	end

	// Watchdog: end the run when nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("bracket_match_stack: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int fills;
		int target;
		int seg;
		int phase;
		fills        = 0;
		phase        = 1;
		sent_count   = 0;
		quiet_cycles = 0;
		gap_pct      = 37;
		sb           = new();
		arst_n <= 1'b0;
		start  <= 1'b0;
		item   <= '0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty close, extreme positions, mismatches, unknown kind
		send_bracket(make_bracket(MODE_CLOSE, KIND_PAREN, '0, '0));
		send_bracket(make_bracket(MODE_OPEN, KIND_PAREN, '1, '1));
		send_bracket(make_bracket(MODE_OPEN, KIND_SQUARE, '0, '0));
		send_bracket(make_bracket(MODE_OPEN, KIND_BRACE, 20'h55555, 16'hAAAA));
		send_bracket(make_bracket(MODE_CLOSE, KIND_PAREN, 20'hAAAAA, 16'h5555));
		send_bracket(make_bracket(MODE_CLOSE, KIND_UNKNOWN, '1, '1));
		send_bracket(make_bracket(MODE_CLOSE, KIND_BRACE, '0, '0));
		send_bracket(make_bracket(MODE_CLOSE, KIND_SQUARE, '1, '0));
		send_bracket(make_bracket(MODE_CLOSE, KIND_PAREN, '0, '1));
		send_bracket(make_bracket(MODE_CLOSE, KIND_SQUARE, '1, '1));
		send_bracket(make_bracket(MODE_OPEN, KIND_UNKNOWN, 20'hAAAAA, 16'h5555));
		send_bracket(make_bracket(MODE_CLOSE, KIND_SQUARE, '0, '0));
		send_bracket(make_bracket(MODE_OPEN, KIND_UNKNOWN, '1, '0));
		send_bracket(make_bracket(MODE_CLOSE, KIND_UNKNOWN, '0, '1));
		send_bracket(make_bracket(MODE_OPEN, KIND_SQUARE, 20'h12345, 16'hFEDC));
		send_bracket(make_bracket(MODE_CLOSE, KIND_UNKNOWN, '0, '0));
		send_bracket(make_bracket(MODE_CLOSE, KIND_BRACE, '0, '0));
		send_bracket(make_bracket(MODE_CLOSE, KIND_SQUARE, '1, '1));
		drain_reports();

		// Random: nesting walks, fills past full, and noise
		while (sent_count < TOTAL_ITEMS) begin
			if (phase == 1 && sent_count >= TOTAL_ITEMS / 3) begin
				drain_reports();
				gap_pct = 54;
				phase   = 2;
			end else if (phase == 2 && sent_count >= 2 * TOTAL_ITEMS / 3) begin
				drain_reports();
				gap_pct = 0;
				phase   = 3;
			end
			seg = $urandom_range(99);
			if ((fills == 0 && sent_count >= 150) || (fills == 1 && sent_count >= 650)) begin
				fills++;
				while (sb.open_count < STACK_SIZE)
					send_bracket(random_open());
				repeat ($urandom_range(3, 1))
					send_bracket(random_open());
				target = $urandom_range(6);
				while (sb.open_count > target) begin
					if ($urandom_range(19) == 0)
						send_bracket(random_bracket());
					else
						send_bracket(matching_close());
				end
			end else if (seg < 70) begin
				repeat ($urandom_range(24, 4)) begin
					if (sb.open_count > 0 && $urandom_range(99) < 55)
						send_bracket(matching_close());
					else
						send_bracket(random_open());
				end
			end else begin
				repeat ($urandom_range(6, 1))
					send_bracket(random_bracket());
			end
		end

		// Wait out the last reports, then allow for stray strobes
		drain_reports();
		repeat (8)
			@(posedge clk);
		if (sb.bad_reports == 0 && sb.pending_reports.size() == 0) begin
			$display("bracket_match_stack: match");
		end else begin
			$display("bracket_match_stack: mismatch");
		end
		$finish;
	end

endmodule
